// ===== hdl/lfp_pkg.sv =====
package lfp_pkg;

  // Framing constants of the sensor protocol.
  localparam logic [7:0] HEADER_BYTE    = 8'h59;
  localparam int         FRAME_BYTES    = 9;
  localparam int         POS_W          = 4;
  localparam logic [POS_W-1:0] POS_HUNT = POS_W'(0);
  localparam logic [POS_W-1:0] POS_HDR2 = POS_W'(1);
  localparam logic [POS_W-1:0] POS_DLO  = POS_W'(2);
  localparam logic [POS_W-1:0] POS_DHI  = POS_W'(3);
  localparam logic [POS_W-1:0] POS_SLO  = POS_W'(4);
  localparam logic [POS_W-1:0] POS_SHI  = POS_W'(5);
  localparam logic [POS_W-1:0] POS_CSUM = POS_W'(FRAME_BYTES - 1);

  // Result status codes.
  localparam int STATUS_W = 2;
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_HDR   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_CSUM  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NO_TARGET = 2'd3;

  // Configuration register map.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_NO_TARGET = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BATCH_LEN = 2'd1;

  localparam int BLEN_W = 6;
  localparam logic [15:0]       NO_TARGET_RST = 16'd45000;
  localparam logic [BLEN_W-1:0] BATCH_LEN_RST = 6'd25;

  localparam int MAX_BATCH_DEF = 32;
  localparam int IDX_W         = 5;
  localparam int QUEUE_DEPTH   = 2;

  // Output stream packing.
  localparam int M_TDATA_W = 40;
  localparam int S_TDATA_W = 8;

  // One parsed frame as it travels from the front end to the back end.
  typedef struct packed {
    logic        hdr_fault;
    logic        csum_ok;
    logic [15:0] distance;
    logic [15:0] strength;
  } frame_rec_t;

endpackage

// ===== hdl/lfp_front.sv =====
module lfp_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                byte_valid_i,
  output logic                byte_ready_o,
  input  logic [7:0]          byte_i,
  output logic                rec_push_o,
  output lfp_pkg::frame_rec_t rec_o,
  input  logic                rec_full_i
);
  import lfp_pkg::*;

  logic [POS_W-1:0] pos_q, pos_d;
  logic [7:0]       sum_q, sum_d;
  logic             fault_q, fault_d;
  logic [15:0]      dist_q, dist_d;
  logic [15:0]      str_q, str_d;
  logic             accept;

  // Bytes are refused only while the queue towards the back end is full.
  assign byte_ready_o = ~rec_full_i;
  assign accept       = byte_valid_i & byte_ready_o;

  always_comb begin
    pos_d   = pos_q;
    sum_d   = sum_q;
    fault_d = fault_q;
    dist_d  = dist_q;
    str_d   = str_q;
    if (accept) begin
      if (pos_q == POS_HUNT) begin
        if (byte_i == HEADER_BYTE) begin
          sum_d   = byte_i;
          fault_d = 1'b0;
          pos_d   = POS_HDR2;
        end
      end else if (pos_q == POS_CSUM) begin
        pos_d = POS_HUNT;
      end else begin
        case (pos_q)
          POS_HDR2: fault_d = (byte_i != HEADER_BYTE);
          POS_DLO:  dist_d[7:0]  = byte_i;
          POS_DHI:  dist_d[15:8] = byte_i;
          POS_SLO:  str_d[7:0]   = byte_i;
          POS_SHI:  str_d[15:8]  = byte_i;
          default:  ;
        endcase
        sum_d = sum_q + byte_i;
        pos_d = pos_q + POS_W'(1);
      end
    end
  end

  assign rec_push_o      = accept & (pos_q == POS_CSUM);
  assign rec_o.hdr_fault = fault_q;
  assign rec_o.csum_ok   = (byte_i == sum_q);
  assign rec_o.distance  = dist_q;
  assign rec_o.strength  = str_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= POS_HUNT;
      sum_q   <= '0;
      fault_q <= 1'b0;
    end else begin
      pos_q   <= pos_d;
      sum_q   <= sum_d;
      fault_q <= fault_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dist_q <= dist_d;
    str_q  <= str_d;
  end

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= POS_CSUM)
    else $error("frame position ran past the checksum byte");

endmodule

// ===== hdl/lfp_queue.sv =====
module lfp_queue #(
  parameter int Depth = lfp_pkg::QUEUE_DEPTH
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  lfp_pkg::frame_rec_t data_i,
  output logic                full_o,
  input  logic                pop_i,
  output logic                valid_o,
  output lfp_pkg::frame_rec_t data_o
);
  import lfp_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  frame_rec_t        mem_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]   count_q;
  logic              do_push, do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign valid_o = (count_q != '0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & valid_o;
  assign data_o  = mem_q[rd_ptr_q];

  function automatic logic [PtrW-1:0] ptr_next(input logic [PtrW-1:0] p);
    ptr_next = (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) wr_ptr_q <= ptr_next(wr_ptr_q);
      if (do_pop)  rd_ptr_q <= ptr_next(rd_ptr_q);
      if (do_push && !do_pop) begin
        count_q <= count_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("queue fill level exceeds its depth");

endmodule

// ===== hdl/lfp_back.sv =====
module lfp_back #(
  parameter int MaxBatch = lfp_pkg::MAX_BATCH_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  input  logic [lfp_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [lfp_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                             rec_valid_i,
  input  lfp_pkg::frame_rec_t              rec_i,
  output logic                             rec_pop_o,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [lfp_pkg::STATUS_W-1:0]     out_status_o,
  output logic [15:0]                      out_distance_o,
  output logic [15:0]                      out_strength_o,
  output logic [lfp_pkg::IDX_W-1:0]        out_index_o,
  output logic                             out_last_o
);
  import lfp_pkg::*;

  localparam int CntW = $clog2(MaxBatch);
  localparam int LenW = $clog2(MaxBatch + 1);
  localparam int CmpW = (LenW > BLEN_W) ? LenW : BLEN_W;

  logic [15:0]       marker_q;
  logic [BLEN_W-1:0] blen_q;
  logic [CntW-1:0]   count_q, count_d;

  logic                valid_q;
  logic [STATUS_W-1:0] status_q, status_d;
  logic [15:0]         dist_q, dist_d;
  logic [15:0]         str_q, str_d;
  logic [IDX_W-1:0]    index_q, index_d;
  logic                last_q, last_d;

  logic [CmpW-1:0]       len;
  logic [CmpW-1:0]       cnt_inc;
  logic [CntW+IDX_W-1:0] cnt_ext;

  // The output register is free when empty or when it is taken this cycle.
  assign rec_pop_o = rec_valid_i & (~valid_q | out_ready_i);

  always_comb begin
    len = CmpW'(blen_q);
    if (blen_q == '0) len = CmpW'(1);
    if (len > CmpW'(MaxBatch)) len = CmpW'(MaxBatch);
  end

  assign cnt_inc = CmpW'(count_q) + CmpW'(1);
  assign cnt_ext = {{IDX_W{1'b0}}, count_q};

  always_comb begin
    count_d  = count_q;
    status_d = ST_OK;
    dist_d   = '0;
    str_d    = '0;
    index_d  = '0;
    last_d   = 1'b0;
    if (rec_i.hdr_fault) begin
      status_d = ST_BAD_HDR;
    end else if (!rec_i.csum_ok) begin
      status_d = ST_BAD_CSUM;
    end else if (rec_i.distance == marker_q) begin
      status_d = ST_NO_TARGET;
      dist_d   = rec_i.distance;
      str_d    = rec_i.strength;
    end else begin
      dist_d  = rec_i.distance;
      str_d   = rec_i.strength;
      index_d = cnt_ext[IDX_W-1:0];
      if (cnt_inc >= len) begin
        last_d  = 1'b1;
        count_d = '0;
      end else begin
        count_d = count_q + CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      marker_q <= NO_TARGET_RST;
      blen_q   <= BATCH_LEN_RST;
      count_q  <= '0;
      valid_q  <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_index_i == CFG_NO_TARGET) marker_q <= cfg_data_i;
      if (cfg_valid_i && cfg_index_i == CFG_BATCH_LEN) blen_q <= cfg_data_i[BLEN_W-1:0];
      if (rec_pop_o) begin
        count_q <= count_d;
        valid_q <= 1'b1;
      end else if (out_ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rec_pop_o) begin
      status_q <= status_d;
      dist_q   <= dist_d;
      str_q    <= str_d;
      index_q  <= index_d;
      last_q   <= last_d;
    end
  end

  assign out_valid_o    = valid_q;
  assign out_status_o   = status_q;
  assign out_distance_o = dist_q;
  assign out_strength_o = str_q;
  assign out_index_o    = index_q;
  assign out_last_o     = last_q;

  a_err_no_batch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && status_q != ST_OK |-> index_q == '0 && !last_q)
    else $error("a frame that is not ok carries batch information");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CmpW'(count_q) < CmpW'(MaxBatch))
    else $error("batch counter reached the batch limit");

  a_err_keeps_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rec_pop_o && status_d != ST_OK |=> $stable(count_q))
    else $error("a rejected frame moved the batch counter");

endmodule

// ===== hdl/lidar_frame_parser.sv =====
// Channel   | Direction | Handshake                     | Payload
// ----------+-----------+-------------------------------+--------------------------------
// byte in   | in        | s_axis_tvalid / s_axis_tready | s_axis_tdata: rx_byte
// result    | out       | m_axis_tvalid / m_axis_tready | tdata, tuser, tlast (see ports)
// config    | in        | cfg_valid_i / cfg_ready_o     | cfg_index_i, cfg_data_i
//
// One byte item is taken per clock cycle unless the input stalls; a frame of nine bytes
// is written into the queue as its checksum byte is taken and moves on into the output
// register once that register is free. Reset is asynchronous and active low; no
// clearing pass follows it, so the block is ready as soon as reset is released. The
// input stalls only when the two-entry frame queue is full, which happens only while
// the result output is held.
module lidar_frame_parser #(
  parameter int MAX_BATCH = lfp_pkg::MAX_BATCH_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Received bytes: [7:0] rx_byte.
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [lfp_pkg::S_TDATA_W-1:0]    s_axis_tdata,
  // Results. tdata: [15:0] distance, [31:16] signal_strength, [36:32] sample_index,
  // [39:37] zero. tuser: [1:0] frame_status. tlast: batch_end.
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [lfp_pkg::M_TDATA_W-1:0]    m_axis_tdata,
  output logic [lfp_pkg::STATUS_W-1:0]     m_axis_tuser,
  output logic                             m_axis_tlast,
  // Register writes: index 0 is the no-target marker, index 1 the batch length.
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [lfp_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [lfp_pkg::CFG_DATA_W-1:0]   cfg_data_i
);
  import lfp_pkg::*;

  frame_rec_t       push_rec, pop_rec;
  logic             push, full, pop, rec_valid;
  logic [15:0]      distance, strength;
  logic [IDX_W-1:0] sample_index;

  // The front end follows the byte position within a frame, keeps the running
  // checksum and captures the distance and strength bytes. On the checksum byte it
  // hands one frame item to the queue.
  lfp_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_valid_i (s_axis_tvalid),
    .byte_ready_o (s_axis_tready),
    .byte_i       (s_axis_tdata),
    .rec_push_o   (push),
    .rec_o        (push_rec),
    .rec_full_i   (full)
  );

  lfp_queue #(
    .Depth (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_rec),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (rec_valid),
    .data_o  (pop_rec)
  );

  // The back end grades each frame, runs the batch counter and holds the result in
  // the output register until the sink takes it.
  lfp_back #(
    .MaxBatch (MAX_BATCH)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .rec_valid_i    (rec_valid),
    .rec_i          (pop_rec),
    .rec_pop_o      (pop),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .out_status_o   (m_axis_tuser),
    .out_distance_o (distance),
    .out_strength_o (strength),
    .out_index_o    (sample_index),
    .out_last_o     (m_axis_tlast)
  );

  // Register writes are always taken.
  assign cfg_ready_o  = 1'b1;
  assign m_axis_tdata = {3'b000, sample_index, strength, distance};

endmodule

// ===== sim/lidar_frame_parser_test.sv =====
module lidar_frame_parser_test;
  import lfp_pkg::*;

  localparam int RUN_LIMIT_CYCLES = 300000;
  // A result passes the frame queue and output register before it is offered; ample.
  localparam int SETTLE_CYCLES    = 8;
  localparam int PHASES           = 6;
  localparam int BYTES_PER_PHASE  = 230;

  // Register indexes past the end of the map; writes to them must be ignored.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [15:0]         distance;
    logic [15:0]         strength;
    logic [IDX_W-1:0]    index;
    logic                batch_end;
  } range_result_t;

  // One byte of the directed sequence. Where has_exp is set, the result of the
  // frame closed by this byte is written out by hand (index and batch end zero).
  typedef struct packed {
    logic [7:0]          rx;
    logic                has_exp;
    logic [STATUS_W-1:0] status;
    logic [15:0]         distance;
    logic [15:0]         strength;
  } stim_row_t;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [S_TDATA_W-1:0]   s_axis_tdata;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [M_TDATA_W-1:0]   m_axis_tdata;
  logic [STATUS_W-1:0]    m_axis_tuser;
  logic                   m_axis_tlast;
  logic                   cfg_valid_i;
  logic                   cfg_ready_o;
  logic [CFG_IDX_W-1:0]   cfg_index_i;
  logic [CFG_DATA_W-1:0]  cfg_data_i;

  lidar_frame_parser uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // Parser state as the testbench sees it, starting from the reset values.
  logic [15:0]       marker_cfg    = NO_TARGET_RST;
  logic [BLEN_W-1:0] batch_len_cfg = BATCH_LEN_RST;
  logic [POS_W-1:0]  frame_pos     = POS_HUNT;
  logic [7:0]        byte_sum      = '0;
  logic              hdr_bad       = 1'b0;
  logic [15:0]       dist_hold     = '0;
  logic [15:0]       str_hold      = '0;
  logic [IDX_W-1:0]  batch_cnt     = '0;

  range_result_t pending_ranges_q [$];

  int  error_count  = 0;
  int  phase_no     = -1;
  int  phase_bytes  = 0;
  bit  src_idle_on  = 1'b1;
  bit  sink_idle_on = 1'b1;
  int  sink_gap     = 0;
  logic sink_hold;

  // Settings per phase; phase 0 runs on the reset values and writes nothing.
  // Batch lengths: zero (taken as one), the largest, one with stray upper bits
  // that leaves three (and lowers the length mid-batch), one above the limit.
  logic [15:0] phase_marker [PHASES] = '{16'd0, 16'h0000, 16'hFFFF, 16'h8000, 16'h1234,
                                         16'h00FF};
  logic [15:0] phase_blen   [PHASES] = '{16'd0, 16'h0000, 16'd32, 16'hFFC3, 16'd63, 16'd7};

  // Directed part: a dropped byte while hunting, a frame with a bad second
  // header byte (and a wrong checksum, which must lose to the header fault), a
  // frame of all-ones payload with a wrong checksum, and a no-target frame
  // carrying the reset marker 45000.
  stim_row_t directed_rows [28] = '{
    '{8'h00, 1'b0, ST_OK,        16'd0,     16'd0},
    '{8'h59, 1'b0, ST_OK,        16'd0,     16'd0},
    '{8'hFF, 1'b0, ST_OK,        16'd0,     16'd0},
    '{8'h12, 1'b0, ST_OK,        16'd0,     16'd0},
    '{8'h34, 1'b0, ST_OK,        16'd0,     16'd0},
    '{8'h56, 1'b0, ST_OK,        16'd0,     16'd0},
    '{8'h78, 1'b0, ST_OK,        16'd0,     16'd0},
    '{8'h9A, 1'b0, ST_OK,        16'd0,     16'd0},
    '{8'hBC, 1'b0, ST_OK,        16'd0,     16'd0},
    '{8'h00, 1'b1, ST_BAD_HDR,   16'd0,     16'd0},
    '{8'h59, 1'b0, ST_OK,        16'd0,     16'd0},
    '{8'h59, 1'b0, ST_OK,        16'd0,     16'd0},
    '{8'hFF, 1'b0, ST_OK,        16'd0,     16'd0},
    '{8'hFF, 1'b0, ST_OK,        16'd0,     16'd0},
    '{8'hFF, 1'b0, ST_OK,        16'd0,     16'd0},
    '{8'hFF, 1'b0, ST_OK,        16'd0,     16'd0},
    '{8'hFF, 1'b0, ST_OK,        16'd0,     16'd0},
    '{8'hFF, 1'b0, ST_OK,        16'd0,     16'd0},
    '{8'h00, 1'b1, ST_BAD_CSUM,  16'd0,     16'd0},
    '{8'h59, 1'b0, ST_OK,        16'd0,     16'd0},
    '{8'h59, 1'b0, ST_OK,        16'd0,     16'd0},
    '{8'hC8, 1'b0, ST_OK,        16'd0,     16'd0},
    '{8'hAF, 1'b0, ST_OK,        16'd0,     16'd0},
    '{8'h34, 1'b0, ST_OK,        16'd0,     16'd0},
    '{8'h12, 1'b0, ST_OK,        16'd0,     16'd0},
    '{8'h00, 1'b0, ST_OK,        16'd0,     16'd0},
    '{8'h00, 1'b0, ST_OK,        16'd0,     16'd0},
    '{8'h6F, 1'b1, ST_NO_TARGET, 16'd45000, 16'h1234}
  };

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch in %s: got %0h, expected %0h", what, got, want);
    error_count++;
  endtask

  // Advances the parser state by one received byte and gives the result that
  // the byte closes, if it is the checksum byte of a frame.
  task automatic parse_byte(input logic [7:0] b, output bit has_res,
                            output range_result_t res);
    int len;
    has_res = 1'b0;
    res     = '0;
    if (frame_pos == POS_HUNT) begin
      if (b == HEADER_BYTE) begin
        byte_sum  = b;
        hdr_bad   = 1'b0;
        dist_hold = '0;
        str_hold  = '0;
        frame_pos = POS_HDR2;
      end
    end else if (frame_pos != POS_CSUM) begin
      case (frame_pos)
        POS_HDR2: if (b != HEADER_BYTE) hdr_bad = 1'b1;
        POS_DLO:  dist_hold[7:0]  = b;
        POS_DHI:  dist_hold[15:8] = b;
        POS_SLO:  str_hold[7:0]   = b;
        POS_SHI:  str_hold[15:8]  = b;
        default:  ;
      endcase
      byte_sum  = byte_sum + b;
      frame_pos = frame_pos + 1'b1;
    end else begin
      frame_pos = POS_HUNT;
      has_res   = 1'b1;
      if (hdr_bad) begin
        res.status = ST_BAD_HDR;
      end else if (b != byte_sum) begin
        res.status = ST_BAD_CSUM;
      end else if (dist_hold == marker_cfg) begin
        res.status   = ST_NO_TARGET;
        res.distance = dist_hold;
        res.strength = str_hold;
      end else begin
        res.status   = ST_OK;
        res.distance = dist_hold;
        res.strength = str_hold;
        len = int'(batch_len_cfg);
        if (len == 0) len = 1;
        if (len > MAX_BATCH_DEF) len = MAX_BATCH_DEF;
        res.index = batch_cnt;
        if (int'(batch_cnt) + 1 >= len) begin
          res.batch_end = 1'b1;
          batch_cnt     = '0;
        end else begin
          batch_cnt = batch_cnt + 1'b1;
        end
      end
    end
  endtask

  // The caller lowers cfg_valid_i after its last write, so that back-to-back
  // writes keep the valid high without a drop in between.
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      CFG_NO_TARGET: marker_cfg    = value;
      CFG_BATCH_LEN: batch_len_cfg = value[BLEN_W-1:0];
      default:       ;
    endcase
  endtask

  task automatic send_byte(input logic [7:0] b, input bit use_given,
                           input range_result_t given);
    bit            has_res;
    range_result_t res;
    if (src_idle_on && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    parse_byte(b, has_res, res);
    if (has_res) pending_ranges_q.push_back(use_given ? given : res);
    phase_bytes++;
  endtask

  // Mostly well-formed frames with random content; some with a bad second
  // header byte or a wrong checksum, some cut short, some after line noise.
  task automatic send_random_frame();
    logic [7:0]  fb [9];
    logic [15:0] dist_word;
    logic [7:0]  csum;
    int          pick;
    int          cut;
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)), 1'b0, '0);
    end
    case ($urandom_range(0, 7))
      0, 1, 2: dist_word = marker_cfg;
      3:       dist_word = 16'h0000;
      4:       dist_word = 16'hFFFF;
      default: dist_word = 16'($urandom_range(0, 65535));
    endcase
    fb[0] = HEADER_BYTE;
    fb[1] = HEADER_BYTE;
    if (pick >= 8 && pick < 18) begin
      fb[1] = 8'($urandom_range(0, 255));
      if (fb[1] == HEADER_BYTE) fb[1] = 8'h00;
    end
    fb[2] = dist_word[7:0];
    fb[3] = dist_word[15:8];
    for (int i = 4; i < 8; i++) fb[i] = 8'($urandom_range(0, 255));
    csum = '0;
    for (int i = 0; i < 8; i++) csum = csum + fb[i];
    if (pick >= 18 && pick < 28) csum = csum + 8'($urandom_range(1, 255));
    fb[8] = csum;
    cut = (pick >= 28 && pick < 33) ? $urandom_range(1, 8) : 9;
    for (int i = 0; i < cut; i++) send_byte(fb[i], 1'b0, '0);
  endtask

  // Result side: checks every accepted result and throttles tready.
  initial begin
    range_result_t want;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_ranges_q.size() == 0) begin
          report_mismatch("result with none pending", m_axis_tdata[31:0], '0);
        end else begin
          want = pending_ranges_q.pop_front();
          if (m_axis_tuser != want.status)
            report_mismatch("frame_status", m_axis_tuser, want.status);
          if (m_axis_tdata[15:0] != want.distance)
            report_mismatch("distance", m_axis_tdata[15:0], want.distance);
          if (m_axis_tdata[31:16] != want.strength)
            report_mismatch("signal_strength", m_axis_tdata[31:16], want.strength);
          if (m_axis_tdata[36:32] != want.index)
            report_mismatch("sample_index", m_axis_tdata[36:32], want.index);
          if (m_axis_tdata[M_TDATA_W-1:37] != '0)
            report_mismatch("tdata padding", m_axis_tdata[M_TDATA_W-1:37], '0);
          if (m_axis_tlast != want.batch_end)
            report_mismatch("batch_end", m_axis_tlast, want.batch_end);
        end
      end
      if (sink_gap > 0) sink_gap--;
      else if (sink_idle_on && $urandom_range(0, 5) == 0) sink_gap = $urandom_range(1, 10);
      m_axis_tready <= !(sink_hold || sink_gap > 0);
    end
  end

  // One long hold-off on the result side while bytes keep coming, so that the
  // frame queue fills and the byte input has to stall.
  initial begin
    sink_hold <= 1'b0;
    wait (phase_no == 2);
    repeat (30) @(posedge clk_i);
    sink_hold <= 1'b1;
    repeat (150) @(posedge clk_i);
    sink_hold <= 1'b0;
  end

  initial begin
    int cycles;
    cycles = 0;
    while (cycles < RUN_LIMIT_CYCLES) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("FAIL lidar_frame_parser");
    $finish;
  end

  initial begin
    range_result_t given;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    cfg_valid_i   <= 1'b0;
    cfg_index_i   <= CFG_NO_TARGET;
    cfg_data_i    <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int p = 0; p < PHASES; p++) begin
      phase_no     = p;
      src_idle_on  = (p != PHASES - 1);
      sink_idle_on = (p != PHASES - 1);
      if (p > 0) begin
        write_register(CFG_NO_TARGET, phase_marker[p]);
        write_register(CFG_BATCH_LEN, phase_blen[p]);
        if (p == 1) write_register(CFG_SPARE_2, 16'hFFFF);
        if (p == 2) write_register(CFG_SPARE_3, 16'h0001);
        cfg_valid_i <= 1'b0;
      end
      phase_bytes = 0;
      if (p == 0) begin
        foreach (directed_rows[i]) begin
          given          = '0;
          given.status   = directed_rows[i].status;
          given.distance = directed_rows[i].distance;
          given.strength = directed_rows[i].strength;
          send_byte(directed_rows[i].rx, directed_rows[i].has_exp, given);
        end
      end
      while (phase_bytes < BYTES_PER_PHASE) send_random_frame();
      s_axis_tvalid <= 1'b0;
      // Drain before touching the registers: every result in, then a margin
      // for a frame that may still be on its way through the block.
      while (pending_ranges_q.size() != 0) @(posedge clk_i);
      repeat (SETTLE_CYCLES) @(posedge clk_i);
    end

    if (error_count == 0) begin
      $display("PASS lidar_frame_parser");
    end else begin
      $display("FAIL lidar_frame_parser");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/lfp_pkg.sv
hdl/lfp_front.sv
hdl/lfp_queue.sv
hdl/lfp_back.sv
hdl/lidar_frame_parser.sv
sim/lidar_frame_parser_test.sv
